>>> hdl/prc_pkg.sv
// Shared types and constants for the perceptron row classifier.
// No dependencies; used by prc_mac and perceptron_row_classifier.
`default_nettype none

package prc_pkg;

  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned PROD_W   = WEIGHT_W + PIX_W + 1;

  localparam int unsigned NUM_FEATURES_DEF   = 49;
  localparam int unsigned ROWS_PER_IMAGE_DEF = 48;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // 100000000 scaled by 2^8
  localparam logic signed [SUM_W-1:0] THRESHOLD_RESET = 48'sd25600000000;

  typedef enum logic {
    ACT_LOAD_WEIGHT = 1'b0,
    ACT_FEATURE     = 1'b1
  } action_e;

  typedef struct packed {
    action_e                     action;
    logic [IDX_W-1:0]            weight_index;
    logic signed [WEIGHT_W-1:0]  weight_value;
    logic [PIX_W-1:0]            pixel;
  } in_item_t;

  typedef struct packed {
    logic             row_positive;
    logic [CNT_W-1:0] positive_rows_in_image;
    logic             image_done;
  } out_item_t;

  // Per-stage control for the multiply-accumulate pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> hdl/prc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module prc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/prc_mac.sv
// Multiply-accumulate pipeline: weight times pixel, then saturating row sum.
// Depends on prc_pkg.
`default_nettype none

module prc_mac import prc_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire mac_ctl_t                   ctl_i,
  input  wire logic [PIX_W-1:0]           pixel_i,
  input  wire logic signed [WEIGHT_W-1:0] weight_i,
  output logic                            fin_vld_o,
  output logic signed [SUM_W-1:0]         fin_sum_o
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  mac_ctl_t                   s1_ctl_q, s2_ctl_q;
  logic [PIX_W-1:0]           s1_pix_q;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [SUM_W-1:0]    row_sum_q, sum_sat;
  logic signed [SUM_W:0]      sum_wide;
  logic                       fin_vld_q;
  logic signed [SUM_W-1:0]    fin_sum_q;

  // Weight arrives from the RAM in the cycle after the pixel; line them up here
  assign prod_d = weight_i * $signed({1'b0, s1_pix_q});

  assign sum_wide = {row_sum_q[SUM_W-1], row_sum_q}
                  + {{(SUM_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q  <= '0;
      s2_ctl_q  <= '0;
      fin_vld_q <= 1'b0;
      row_sum_q <= '0;
    end else if (en_i) begin
      s1_ctl_q  <= ctl_i;
      s2_ctl_q  <= s1_ctl_q;
      fin_vld_q <= s2_ctl_q.vld & s2_ctl_q.last;
      if (s2_ctl_q.vld) begin
        // clear at row end so the next row starts from zero
        row_sum_q <= s2_ctl_q.last ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pix_q <= pixel_i;
      prod_q   <= prod_d;
      if (s2_ctl_q.vld & s2_ctl_q.last) begin
        fin_sum_q <= sum_sat;
      end
    end
  end

  assign fin_vld_o = fin_vld_q;
  assign fin_sum_o = fin_sum_q;

endmodule

`default_nettype wire

>>> hdl/perceptron_row_classifier.sv
// Perceptron row classifier top level: weight RAM, MAC pipeline, row decision.
// Depends on prc_pkg, prc_ram and prc_mac.
// A row's result passes the MAC registers s1, s2 and fin, then the output register.
// Throughput: one transaction per cycle while not stalled, weight loads and features alike.
// Input stalls only while a finished row waits on a stalled output register.
// Reset: counters and accumulator clear, the threshold returns to its reset value;
// the weight RAM is not cleared.
`default_nettype none

module perceptron_row_classifier import prc_pkg::*; #(
  parameter int unsigned NUM_FEATURES   = NUM_FEATURES_DEF,
  parameter int unsigned ROWS_PER_IMAGE = ROWS_PER_IMAGE_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration: decision threshold
  input  wire logic                    cfg_we_i,
  input  wire logic signed [SUM_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire in_item_t                in_data_i,
  // output channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output out_item_t                    out_data_o
);

  localparam int unsigned AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned RW = (ROWS_PER_IMAGE > 1) ? $clog2(ROWS_PER_IMAGE) : 1;
  localparam logic [AW-1:0] FP_LAST  = AW'(NUM_FEATURES - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS_PER_IMAGE - 1);

  logic                    hold, en, in_acc, is_feat, is_load, fp_last;
  logic                    load_ok;
  logic [AW-1:0]           fp_q, fp_d;
  logic [RW-1:0]           row_q, row_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
  logic signed [SUM_W-1:0] thr_q;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_data_q, out_data_d;
  logic signed [WEIGHT_W-1:0] weight_rd;
  mac_ctl_t                mac_ctl;
  logic                    fin_vld;
  logic signed [SUM_W-1:0] fin_sum;
  logic                    positive, row_done;

  // Freeze the whole pipeline only when a finished row would collide with a
  // result still waiting in the output register.
  assign hold       = fin_vld & out_valid_q & out_stall_i;
  assign en         = ~hold;
  assign in_stall_o = hold;
  assign in_acc     = in_valid_i & ~hold;
  assign is_feat    = in_acc & (in_data_i.action == ACT_FEATURE);
  assign is_load    = in_acc & (in_data_i.action == ACT_LOAD_WEIGHT);
  // drop loads that address beyond the store
  assign load_ok    = 32'(in_data_i.weight_index) < 32'(NUM_FEATURES);
  assign fp_last    = fp_q == FP_LAST;

  // Feature position: advance on each accepted feature, wrap at row end
  always_comb begin
    fp_d = fp_q;
    if (is_feat) begin
      fp_d = fp_last ? '0 : fp_q + AW'(1);
    end
  end

  // Reads and writes both happen at the accept edge, in transaction order, so
  // a load followed by a feature at the same position needs no forwarding.
  prc_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (NUM_FEATURES)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (is_load & load_ok),
    .waddr_i (AW'(in_data_i.weight_index)),
    .wdata_i (in_data_i.weight_value),
    .re_i    (en),
    .raddr_i (fp_q),
    .rdata_o (weight_rd)
  );

  assign mac_ctl.vld  = is_feat;
  assign mac_ctl.last = fp_last;

  prc_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (mac_ctl),
    .pixel_i   (in_data_i.pixel),
    .weight_i  (weight_rd),
    .fin_vld_o (fin_vld),
    .fin_sum_o (fin_sum)
  );

  // Row decision, positive count and image boundary
  assign positive = fin_sum > thr_q;
  assign row_done = row_q == ROW_LAST;
  assign cnt_inc  = (positive && (cnt_q != CNT_MAX)) ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    row_d       = row_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_vld && !hold) begin
      out_valid_d                       = 1'b1;
      out_data_d.row_positive           = positive;
      out_data_d.positive_rows_in_image = cnt_inc;
      out_data_d.image_done             = row_done;
      row_d = row_done ? '0 : row_q + RW'(1);
      cnt_d = row_done ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q        <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      thr_q       <= THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      fp_q        <= fp_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Feature and row positions stay inside their ranges
  a_fp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fp_q <= FP_LAST)
    else $error("feature position out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_LAST)
    else $error("row position out of range");

  // The last feature of a row wraps the position back to zero
  a_fp_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_feat && fp_last |=> fp_q == '0)
    else $error("feature position did not wrap at row end");

  // A finished row always lands in the output register unless held
  a_fin_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld && !hold |=> out_valid_q)
    else $error("finished row lost");

endmodule

`default_nettype wire
